// ----- hw/rtl/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
// Used by spq_cell, spq_ctrl, the top level and the checker.
package spq_pkg;

  localparam int VALUE_W  = 32;
  localparam int PRIO_W   = 3;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENQ = 2'd0,
    FUNC_DEQ = 2'd1,
    FUNC_WDR = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ENQ,
    CELL_DEQ,
    CELL_WDR
  } cell_op_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    cell_op_t op;
  } cell_cmd_t;

endpackage

// ----- hw/rtl/sorted_priority_queue_unit.sv -----
// Top level of the sorted priority queue: controller plus a chain of CAPACITY cells.
// Depends on spq_pkg, spq_cell and spq_ctrl.
//
//   channel  dir  handshake           payload
//   in       in   in_valid/in_stall   in_func, in_value, in_priority_req
//   out      out  out_valid/out_stall out_value, out_priority, out_status, out_occupancy
//
// Enqueue and dequeue: every cell decides its shift locally from its neighbors.
// Withdraw first scans the chain: the first-match flag ripples one cell per cycle.
// Reset is synchronous, active low; it empties the queue without clearing the stored entries.
// A held result blocks the next item only when out_stall stays high.
module sorted_priority_queue_unit #(
  parameter int CAPACITY      = 16,
  parameter int PRIORITY_BITS = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spq_pkg::FUNC_W-1:0]    in_func,
  input  logic [31:0]                   in_value,
  input  logic [spq_pkg::PRIO_W-1:0]    in_priority_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   out_value,
  output logic [spq_pkg::PRIO_W-1:0]    out_priority,
  output logic [spq_pkg::STATUS_W-1:0]  out_status,
  output logic [spq_pkg::OCC_W-1:0]     out_occupancy
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  cell_cmd_t                cmd;
  logic [31:0]              key;
  logic [CNT_W-1:0]         count;
  logic [PRIORITY_BITS-1:0] new_prio;
  logic                     found;
  logic [PRIORITY_BITS-1:0] found_prio;

  logic [31:0]              c_value [CAPACITY];
  logic [PRIORITY_BITS-1:0] c_prio  [CAPACITY];
  logic                     c_gt    [CAPACITY];
  logic                     c_match [CAPACITY];
  logic                     c_seen  [CAPACITY];
  logic [PRIORITY_BITS-1:0] c_pf    [CAPACITY];

  assign new_prio = PRIORITY_BITS'(in_priority_req);

  // report the first match at the end of the chain
  assign found      = c_seen[CAPACITY-1] | c_match[CAPACITY-1];
  assign found_prio = c_seen[CAPACITY-1] ? c_pf[CAPACITY-1] : c_prio[CAPACITY-1];

  spq_ctrl #(
    .CAPACITY     (CAPACITY),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_value     (in_value),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_value    (out_value),
    .out_priority (out_priority),
    .out_status   (out_status),
    .out_occupancy(out_occupancy),
    .cmd          (cmd),
    .key          (key),
    .count        (count),
    .head_value   (c_value[0]),
    .head_prio    (c_prio[0]),
    .found        (found),
    .found_prio   (found_prio)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0]              prev_value;
    logic [PRIORITY_BITS-1:0] prev_prio;
    logic                     prev_gt;
    logic                     prev_seen;
    logic                     prev_match;
    logic [PRIORITY_BITS-1:0] prev_pf;
    logic [31:0]              next_value;
    logic [PRIORITY_BITS-1:0] next_prio;

    if (i == 0) begin : g_head
      assign prev_value = in_value;
      assign prev_prio  = new_prio;
      assign prev_gt    = 1'b0;
      assign prev_seen  = 1'b0;
      assign prev_match = 1'b0;
      assign prev_pf    = '0;
    end else begin : g_body
      assign prev_value = c_value[i-1];
      assign prev_prio  = c_prio[i-1];
      assign prev_gt    = c_gt[i-1];
      assign prev_seen  = c_seen[i-1];
      assign prev_match = c_match[i-1];
      assign prev_pf    = c_pf[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_value = c_value[i];
      assign next_prio  = c_prio[i];
    end else begin : g_mid
      assign next_value = c_value[i+1];
      assign next_prio  = c_prio[i+1];
    end

    spq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .occupied  (count > CNT_W'(i)),
      .at_tail   (count == CNT_W'(i)),
      .new_value (in_value),
      .new_prio  (new_prio),
      .key       (key),
      .prev_value(prev_value),
      .prev_prio (prev_prio),
      .prev_gt   (prev_gt),
      .prev_seen (prev_seen),
      .prev_match(prev_match),
      .prev_pf   (prev_pf),
      .next_value(next_value),
      .next_prio (next_prio),
      .value     (c_value[i]),
      .prio      (c_prio[i]),
      .gt        (c_gt[i]),
      .match     (c_match[i]),
      .seen      (c_seen[i]),
      .pf        (c_pf[i])
    );
  end

endmodule

// ----- hw/rtl/spq_cell.sv -----
// One slot of the sorted chain: holds a value and priority, shifts with its neighbors.
// Depends on spq_pkg.
module spq_cell #(
  parameter int PRIORITY_BITS = 3
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  spq_pkg::cell_cmd_t       cmd,
  input  logic                     occupied,
  input  logic                     at_tail,
  input  logic [31:0]              new_value,
  input  logic [PRIORITY_BITS-1:0] new_prio,
  input  logic [31:0]              key,
  input  logic [31:0]              prev_value,
  input  logic [PRIORITY_BITS-1:0] prev_prio,
  input  logic                     prev_gt,
  input  logic                     prev_seen,
  input  logic                     prev_match,
  input  logic [PRIORITY_BITS-1:0] prev_pf,
  input  logic [31:0]              next_value,
  input  logic [PRIORITY_BITS-1:0] next_prio,
  output logic [31:0]              value,
  output logic [PRIORITY_BITS-1:0] prio,
  output logic                     gt,
  output logic                     match,
  output logic                     seen,
  output logic [PRIORITY_BITS-1:0] pf
);
  import spq_pkg::*;

  logic [31:0]              value_r, value_nxt;
  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;
  logic                     seen_r, seen_nxt;
  logic [PRIORITY_BITS-1:0] pf_r, pf_nxt;

  always_comb begin
    gt        = occupied && (prio_r > new_prio);
    match     = occupied && (value_r == key);
    value_nxt = value_r;
    prio_nxt  = prio_r;
    case (cmd.op)
      CELL_ENQ: begin
        if (prev_gt) begin
          value_nxt = prev_value;
          prio_nxt  = prev_prio;
        end else if (gt || at_tail) begin
          value_nxt = new_value;
          prio_nxt  = new_prio;
        end
      end
      CELL_DEQ: begin
        value_nxt = next_value;
        prio_nxt  = next_prio;
      end
      CELL_WDR: begin
        if (seen_r || match) begin
          value_nxt = next_value;
          prio_nxt  = next_prio;
        end
      end
      default: begin
      end
    endcase
  end

  // ripple: is there a match ahead of this cell, and its priority
  assign seen_nxt = prev_seen | prev_match;
  assign pf_nxt   = prev_seen ? prev_pf : prev_prio;

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
    pf_r    <= pf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  assign value = value_r;
  assign prio  = prio_r;
  assign seen  = seen_r;
  assign pf    = pf_r;

endmodule

// ----- hw/rtl/spq_ctrl.sv -----
// Controller: handshakes, entry count, withdraw scan sequencing and result register.
// Depends on spq_pkg.
module spq_ctrl #(
  parameter int CAPACITY      = 16,
  parameter int PRIORITY_BITS = 3,
  localparam int CNT_W        = $clog2(CAPACITY + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spq_pkg::FUNC_W-1:0]    in_func,
  input  logic [31:0]                   in_value,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [31:0]                   out_value,
  output logic [spq_pkg::PRIO_W-1:0]    out_priority,
  output logic [spq_pkg::STATUS_W-1:0]  out_status,
  output logic [spq_pkg::OCC_W-1:0]     out_occupancy,
  output spq_pkg::cell_cmd_t            cmd,
  output logic [31:0]                   key,
  output logic [CNT_W-1:0]              count,
  input  logic [31:0]                   head_value,
  input  logic [PRIORITY_BITS-1:0]      head_prio,
  input  logic                          found,
  input  logic [PRIORITY_BITS-1:0]      found_prio
);
  import spq_pkg::*;

  localparam int SCAN_W = $clog2(CAPACITY);

  state_t              state_r, state_nxt;
  logic [SCAN_W-1:0]   scan_r, scan_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [31:0]         key_r, key_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         res_value_r, res_value_nxt;
  logic [PRIO_W-1:0]   res_prio_r, res_prio_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [OCC_W-1:0]    res_occ_r, res_occ_nxt;
  logic                out_free;
  logic                accept;
  logic                load_out;

  assign out_free = !out_valid_r || !out_stall;
  assign accept   = in_valid && (state_r == S_IDLE) && out_free;
  assign in_stall = !((state_r == S_IDLE) && out_free);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept && (func_t'(in_func) == FUNC_WDR)) state_nxt = S_SCAN;
      S_SCAN: if (scan_r == SCAN_W'(CAPACITY - 1)) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op         = CELL_HOLD;
    load_out       = 1'b0;
    count_nxt      = count_r;
    key_nxt        = key_r;
    scan_nxt       = scan_r;
    res_value_nxt  = 32'd0;
    res_prio_nxt   = '0;
    res_status_nxt = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        scan_nxt = '0;
        if (accept) begin
          load_out = 1'b1;
          unique case (func_t'(in_func))
            FUNC_ENQ: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                res_status_nxt = ST_FULL;
              end else begin
                cmd.op    = CELL_ENQ;
                count_nxt = count_r + 1'b1;
              end
            end
            FUNC_DEQ: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                cmd.op        = CELL_DEQ;
                count_nxt     = count_r - 1'b1;
                res_value_nxt = head_value;
                res_prio_nxt  = PRIO_W'(head_prio);
              end
            end
            FUNC_WDR: begin
              load_out = 1'b0;
              key_nxt  = in_value;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        scan_nxt = scan_r + 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          if (found) begin
            cmd.op        = CELL_WDR;
            count_nxt     = count_r - 1'b1;
            res_value_nxt = key_r;
            res_prio_nxt  = PRIO_W'(found_prio);
          end else begin
            res_status_nxt = ST_NOT_FOUND;
          end
        end
      end
      default: begin
      end
    endcase
    res_occ_nxt = OCC_W'(count_nxt);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (load_out) begin
      res_value_r  <= res_value_nxt;
      res_prio_r   <= res_prio_nxt;
      res_status_r <= res_status_nxt;
      res_occ_r    <= res_occ_nxt;
    end
  end

  assign key           = key_r;
  assign count         = count_r;
  assign out_valid     = out_valid_r;
  assign out_value     = res_value_r;
  assign out_priority  = res_prio_r;
  assign out_status    = res_status_r;
  assign out_occupancy = res_occ_r;

endmodule

// ----- hw/rtl/spq_checker.sv -----
// Port-level checker for sorted_priority_queue_unit, attached by bind.
// Depends on spq_pkg.
module spq_port_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [31:0]                   out_value,
  input logic [spq_pkg::PRIO_W-1:0]    out_priority,
  input logic [spq_pkg::STATUS_W-1:0]  out_status,
  input logic [spq_pkg::OCC_W-1:0]     out_occupancy
);
  import spq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_value == 32'd0 && out_priority == '0)
    else $error("failed item carries a payload");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_occupancy == '0)
    else $error("empty status with nonzero occupancy");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind sorted_priority_queue_unit spq_port_checker u_spq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_value    (out_value),
  .out_priority (out_priority),
  .out_status   (out_status),
  .out_occupancy(out_occupancy)
);

// ----- bench/spq_checker.sv -----
// Checker for the sorted priority queue: watches both channels, keeps its own
// copy of the queue and compares every result with the one it predicts.
// Depends on spq_pkg.
module spq_checker import spq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic [PRIO_W-1:0]   in_priority_req,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [VALUE_W-1:0]  out_value,
  input  logic [PRIO_W-1:0]   out_priority,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [OCC_W-1:0]    out_occupancy,
  output int                  fail_count,
  output int                  due_count
);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]  prio;
    status_t            status;
    logic [OCC_W-1:0]   occ;
  } reply_t;

  entry_t held_entries[$];
  reply_t due_replies[$];
  int     mismatches = 0;
  int     waiting = 0;

  assign fail_count = mismatches;
  assign due_count  = waiting;

  function automatic reply_t serve_request(logic [FUNC_W-1:0] func,
                                           logic [VALUE_W-1:0] value,
                                           logic [PRIO_W-1:0] prio);
    reply_t r;
    entry_t e;
    int     pos;
    r.value  = '0;
    r.prio   = '0;
    r.status = ST_OK;
    pos      = 0;
    case (func)
      FUNC_ENQ: begin
        if (held_entries.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          while (pos < held_entries.size() && held_entries[pos].prio <= prio) pos++;
          e.value = value;
          e.prio  = prio;
          held_entries.insert(pos, e);
        end
      end
      FUNC_DEQ: begin
        if (held_entries.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = held_entries[0].value;
          r.prio  = held_entries[0].prio;
          held_entries.delete(0);
        end
      end
      FUNC_WDR: begin
        while (pos < held_entries.size() && held_entries[pos].value != value) pos++;
        if (pos < held_entries.size()) begin
          r.value = held_entries[pos].value;
          r.prio  = held_entries[pos].prio;
          held_entries.delete(pos);
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    r.occ = OCC_W'(held_entries.size());
    return r;
  endfunction

  task automatic match_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      held_entries.delete();
      due_replies.delete();
    end else begin
      if (in_valid && !in_stall) begin
        due_replies.push_back(serve_request(in_func, in_value, in_priority_req));
      end
      if (out_valid && !out_stall) begin
        if (due_replies.size() == 0) begin
          $error("out: result with no request waiting");
          mismatches++;
        end else begin
          want = due_replies.pop_front();
          match_field("out_value", want.value, out_value);
          match_field("out_priority", 32'(want.prio), 32'(out_priority));
          match_field("out_status", 32'(want.status), 32'(out_status));
          match_field("out_occupancy", 32'(want.occ), 32'(out_occupancy));
        end
      end
    end
    waiting = due_replies.size();
  end

endmodule

// ----- bench/sorted_priority_queue_unit_tb.sv -----
// Testbench top for sorted_priority_queue_unit: drives directed and random
// enqueue, dequeue, withdraw and unused-code requests with random gaps and stalls.
// Depends on spq_pkg, spq_checker and the block itself.
module sorted_priority_queue_unit_tb;
  import spq_pkg::*;

  localparam int CAPACITY     = 16;
  localparam int RANDOM_ITEMS = 1800;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   in_func = FUNC_ENQ;
  logic [31:0]         in_value = '0;
  logic [PRIO_W-1:0]   in_priority_req = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [31:0]         out_value;
  logic [PRIO_W-1:0]   out_priority;
  logic [STATUS_W-1:0] out_status;
  logic [OCC_W-1:0]    out_occupancy;

  int          fail_count;
  int          due_count;
  int          idle_cycles = 0;
  int          stall_left = 0;
  bit          in_idle = 1'b1;
  bit          out_idle = 1'b1;
  bit          out_fire = 1'b0;
  logic [31:0] recent_values[$];

  always #5 clk = ~clk;

  sorted_priority_queue_unit #(
    .CAPACITY      (CAPACITY),
    .PRIORITY_BITS (PRIO_W)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_value        (in_value),
    .in_priority_req (in_priority_req),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value       (out_value),
    .out_priority    (out_priority),
    .out_status      (out_status),
    .out_occupancy   (out_occupancy)
  );

  spq_checker #(
    .CAPACITY (CAPACITY)
  ) u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_value        (in_value),
    .in_priority_req (in_priority_req),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value       (out_value),
    .out_priority    (out_priority),
    .out_status      (out_status),
    .out_occupancy   (out_occupancy),
    .fail_count      (fail_count),
    .due_count       (due_count)
  );

  always @(posedge clk) begin
    out_fire <= out_valid && !out_stall;
  end

  always @(negedge clk) begin
    if (out_fire) begin
      if ($urandom_range(0, 39) == 0) out_idle = !out_idle;
      stall_left = out_idle ? $urandom_range(0, 15) : 0;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** sorted_priority_queue_unit: FAILED **");
      $finish;
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FC0_0000;
      4, 5: return 32'($urandom_range(1, 6));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] withdraw_value();
    if (recent_values.size() > 0 && $urandom_range(0, 3) != 0) begin
      return recent_values[$urandom_range(0, recent_values.size() - 1)];
    end
    return rand_value();
  endfunction

  task automatic push_op(logic [FUNC_W-1:0] func, logic [31:0] value,
                         logic [PRIO_W-1:0] prio);
    int gap;
    gap = in_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= func;
    in_value        <= value;
    in_priority_req <= prio;
    do @(posedge clk); while (in_stall);
    if (func == FUNC_ENQ) begin
      recent_values.push_back(value);
      if (recent_values.size() > 24) recent_values.delete(0);
    end
    @(negedge clk);
  endtask

  initial begin
    int roll;
    int enq_weight;
    enq_weight = 50;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_op(FUNC_DEQ, 32'h0, 3'd0);
    push_op(FUNC_WDR, 32'h0, 3'd0);
    push_op(FUNC_UNUSED, 32'hFFFF_FFFF, 3'd7);
    push_op(FUNC_ENQ, 32'hFFFF_FFFF, 3'd7);
    push_op(FUNC_ENQ, 32'h0000_0000, 3'd0);
    push_op(FUNC_ENQ, 32'h8000_0000, 3'd3);
    push_op(FUNC_ENQ, 32'h7FC0_0000, 3'd3);
    push_op(FUNC_WDR, 32'h0000_0000, 3'd0);
    push_op(FUNC_WDR, 32'h7FC0_0000, 3'd5);
    push_op(FUNC_WDR, 32'h1234_5678, 3'd0);
    repeat (CAPACITY - 2) push_op(FUNC_ENQ, rand_value(), PRIO_W'($urandom_range(0, 7)));
    push_op(FUNC_ENQ, 32'hA5A5_A5A5, 3'd2);
    push_op(FUNC_DEQ, 32'h0, 3'd0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        enq_weight = $urandom_range(25, 75);
        in_idle    = $urandom_range(0, 2) != 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        push_op(FUNC_UNUSED, $urandom, PRIO_W'($urandom_range(0, 7)));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < enq_weight) begin
          push_op(FUNC_ENQ, rand_value(), PRIO_W'($urandom_range(0, 7)));
        end else if (roll < enq_weight + (100 - enq_weight) / 2) begin
          push_op(FUNC_DEQ, $urandom, PRIO_W'($urandom_range(0, 7)));
        end else begin
          push_op(FUNC_WDR, withdraw_value(), PRIO_W'($urandom_range(0, 7)));
        end
      end
    end
    in_valid <= 1'b0;

    wait (due_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("** sorted_priority_queue_unit: PASSED **");
    end else begin
      $display("** sorted_priority_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule
